/* hw/rtl/acp_pkg.sv */
package acp_pkg;

	localparam int unsigned PENDING_CAPACITY_DEF = 4096;

	localparam int unsigned FRAMES_W = 13;
	localparam int unsigned TIME_W   = 63;
	localparam int unsigned OFFSET_W = 40;
	localparam int unsigned RATE_W   = 20;
	localparam int unsigned DUR_W    = 16;
	localparam int unsigned SIZE_W   = FRAMES_W + 1;
	localparam int unsigned CNT_W    = 7;

	localparam int unsigned MD_A_W = OFFSET_W;
	localparam int unsigned MD_B_W = 30;
	localparam int unsigned MD_D_W = RATE_W;
	localparam int unsigned MD_P_W = MD_A_W + MD_B_W;

	localparam logic [MD_B_W-1:0]   NS_PER_SEC = MD_B_W'(1000000000);
	localparam logic [TIME_W-1:0]   MAX63      = {TIME_W{1'b1}};
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
	localparam logic [FRAMES_W-1:0] BASE_MAX   = {FRAMES_W{1'b1}};

	localparam logic [CNT_W-1:0] MAX_RESULTS = CNT_W'(64);

	localparam int unsigned RATE_RST = 48000;
	localparam int unsigned NUM_RST  = 1;
	localparam int unsigned DEN_RST  = 50;
	localparam longint unsigned RST_PROD = longint'(RATE_RST) * longint'(NUM_RST);
	localparam longint unsigned RST_BASE = RST_PROD / DEN_RST;
	localparam longint unsigned RST_REM  = RST_PROD % DEN_RST;
	localparam logic [FRAMES_W-1:0] BASE_RST =
		(RST_BASE > 8191) ? BASE_MAX : FRAMES_W'(RST_BASE);
	localparam logic [DUR_W-1:0] REM_RST = DUR_W'(RST_REM);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = RATE_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION_NUM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION_DEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STRICT_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PLAY = 3'd4;

	localparam logic [1:0] OP_ARRIVAL = 2'd0;
	localparam logic [1:0] OP_DRAIN   = 2'd1;
	localparam logic [1:0] OP_FLUSH   = 2'd2;

	localparam logic [1:0] KIND_CHUNK     = 2'd0;
	localparam logic [1:0] KIND_DISCARDED = 2'd1;
	localparam logic [1:0] KIND_NOT_CFG   = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW  = 2'd3;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [FRAMES_W-1:0] frame_count;
		logic [TIME_W-1:0]   arrival_time;
		logic                discont;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [FRAMES_W-1:0] chunk_frames;
		logic [TIME_W-1:0]   chunk_time;
		logic [TIME_W-1:0]   chunk_length;
		logic                starts_run;
		logic                last;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_D_W-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [MD_P_W-1:0] q;
		logic [MD_D_W-1:0] r;
	} md_rsp_t;

endpackage

/* hw/rtl/acp_muldiv.sv */
module acp_muldiv (
	input  logic            clk,
	input  logic            arst_n,
	input  acp_pkg::md_req_t req,
	output acp_pkg::md_rsp_t rsp
);
	import acp_pkg::*;

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MD_B_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MD_P_W - 1);

	mstate_t             state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MD_P_W-1:0]   p_q;
	logic [MD_P_W-1:0]   a_q;
	logic [MD_B_W-1:0]   b_q;
	logic [MD_D_W-1:0]   d_q;
	logic [MD_D_W:0]     rem_q;
	logic                done_q;
	logic [MD_D_W:0]     nrem;
	logic                fits;

	assign nrem = {rem_q[MD_D_W-1:0], p_q[MD_P_W-1]};
	assign fits = nrem >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						p_q     <= '0;
						a_q     <= MD_P_W'(req.a);
						b_q     <= req.b;
						d_q     <= req.d;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					if (b_q[0]) p_q <= p_q + a_q;
					a_q <= {a_q[MD_P_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[MD_B_W-1:1]};
					if (cnt_q == MUL_LAST) begin
						cnt_q   <= '0;
						state_q <= M_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				M_DIV: begin
					rem_q <= fits ? nrem - {1'b0, d_q} : nrem;
					p_q   <= {p_q[MD_P_W-2:0], fits};
					if (cnt_q == DIV_LAST) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = p_q;
	assign rsp.r    = rem_q[MD_D_W-1:0];

endmodule

/* hw/rtl/audio_chunk_planner_unit.sv */
// Audio chunk planner: counts arriving frames into fixed-duration chunks and emits one beat
// per chunk, discard, overflow or not-configured event, the final beat of an item marked last.
// All time arithmetic runs on one shared multiply-divide unit; each conversion takes 30
// shift-add multiply steps, then 70 restoring divide steps. A chunk costs two conversions
// plus a size test, two launches, two result handoffs and the put, and the put waits while
// the result port stalls. A write to sample_rate, duration_num or duration_den holds both
// ports off while the chunk size is rederived.
module audio_chunk_planner_unit #(
	parameter int unsigned PENDING_CAPACITY = acp_pkg::PENDING_CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  acp_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output acp_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [acp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [acp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import acp_pkg::*;

	localparam int unsigned PW = $clog2(PENDING_CAPACITY + 1);
	localparam int unsigned SW = ((PW > FRAMES_W) ? PW : FRAMES_W) + 1;
	localparam logic [SW-1:0] CAP = SW'(PENDING_CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE, S_RECOMP, S_RECOMP_W, S_DISPATCH, S_DISC_DONE, S_CAP, S_RC_TEST,
		S_CV1, S_CV1_W, S_CV2, S_CV2_W, S_PUT_CHUNK, S_RC_END, S_PUT_ONE, S_FIN
	} state_t;

	state_t               state_q, ret_q, one_ret_q;
	logic [RATE_W-1:0]    rate_q;
	logic [DUR_W-1:0]     num_q, den_q;
	logic                 strict_q, reverse_q;
	logic [PW-1:0]        pending_q;
	logic [DUR_W-1:0]     acc_q, crem_q;
	logic [OFFSET_W-1:0]  roff_q, noff_q;
	logic                 ovalid_q;
	logic [TIME_W-1:0]    rbase_q;
	logic [FRAMES_W-1:0]  base_q;
	in_item_t             item_q;
	logic [CNT_W-1:0]     cnt_q, limit_q;
	logic                 force_q;
	logic [SIZE_W-1:0]    n_q;
	logic                 start_q;
	logic [TIME_W-1:0]    diff_q, t_q, len_q;
	logic [1:0]           one_kind_q;
	logic [FRAMES_W-1:0]  one_frames_q;
	out_item_t            hld_q, out_q;
	logic                 hld_v_q, out_v_q;

	md_req_t              md_req;
	md_rsp_t              md_rsp;

	logic                 put_req, put_stall, put_fire;
	out_item_t            put_data;
	out_item_t            fin_data;
	logic                 fin_move;
	logic [SW-1:0]        pend_ext, sum_ext, size_ext;
	logic [DUR_W:0]       rsum;
	logic                 bump;
	logic [SIZE_W-1:0]    size;
	logic [DUR_W-1:0]     acc_next;
	logic [OFFSET_W:0]    noff_raw;
	logic [TIME_W-1:0]    conv;
	logic [TIME_W:0]      fsum;

	acp_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(md_req), .rsp(md_rsp));

	assign pend_ext = SW'(pending_q);
	assign sum_ext  = pend_ext + SW'(item_q.frame_count);
	assign rsum     = {1'b0, acc_q} + {1'b0, crem_q};
	assign bump     = rsum >= {1'b0, den_q};
	assign acc_next = bump ? DUR_W'(rsum - {1'b0, den_q}) : rsum[DUR_W-1:0];
	assign size     = SIZE_W'(base_q) + SIZE_W'(bump);
	assign size_ext = SW'(size);
	assign conv     = (|md_rsp.q[MD_P_W-1:TIME_W]) ? MAX63 : md_rsp.q[TIME_W-1:0];
	assign fsum     = {1'b0, rbase_q} + {1'b0, diff_q};

	always_comb begin
		md_req.start = 1'b0;
		md_req.a     = roff_q;
		md_req.b     = NS_PER_SEC;
		md_req.d     = rate_q;
		case (state_q)
			S_RECOMP: begin
				md_req.start = (rate_q != '0) && (den_q != '0);
				md_req.a     = MD_A_W'(rate_q);
				md_req.b     = MD_B_W'(num_q);
				md_req.d     = MD_D_W'(den_q);
			end
			S_CV1: md_req.start = 1'b1;
			S_CV2: begin
				md_req.start = 1'b1;
				md_req.a     = reverse_q ? MD_A_W'(n_q) : noff_q;
			end
			default: md_req.start = 1'b0;
		endcase
	end

	always_comb begin
		noff_raw = {1'b0, roff_q} + (OFFSET_W + 1)'(size);
		if (!(pend_ext >= size_ext)) noff_raw = {1'b0, roff_q} + (OFFSET_W + 1)'(pending_q);
	end

	always_comb begin
		put_req  = 1'b0;
		put_data = '0;
		case (state_q)
			S_PUT_CHUNK: begin
				put_req               = 1'b1;
				put_data.kind         = KIND_CHUNK;
				put_data.chunk_frames = n_q[FRAMES_W-1:0];
				put_data.chunk_time   = t_q;
				put_data.chunk_length = len_q;
				put_data.starts_run   = start_q;
			end
			S_PUT_ONE: begin
				put_req               = 1'b1;
				put_data.kind         = one_kind_q;
				put_data.chunk_frames = one_frames_q;
			end
			default: put_req = 1'b0;
		endcase
	end

	always_comb begin
		fin_data      = hld_q;
		fin_data.last = 1'b1;
	end

	assign put_stall = hld_v_q && out_v_q && !out_ready;
	assign put_fire  = put_req && !put_stall;
	assign fin_move  = (state_q == S_FIN) && hld_v_q && (!out_v_q || out_ready);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_FIN;
			one_ret_q <= S_FIN;
			rate_q    <= RATE_W'(RATE_RST);
			num_q     <= DUR_W'(NUM_RST);
			den_q     <= DUR_W'(DEN_RST);
			strict_q  <= 1'b0;
			reverse_q <= 1'b0;
			pending_q <= '0;
			acc_q     <= '0;
			crem_q    <= REM_RST;
			roff_q    <= '0;
			ovalid_q  <= 1'b0;
			rbase_q   <= '0;
			base_q    <= BASE_RST;
			cnt_q     <= '0;
			limit_q   <= '0;
			force_q   <= 1'b0;
			hld_v_q   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_v_q && out_ready && !(put_fire && hld_v_q) && !fin_move) out_v_q <= 1'b0;
			if (put_fire) begin
				if (hld_v_q) begin
					out_q   <= hld_q;
					out_v_q <= 1'b1;
				end
				hld_q   <= put_data;
				hld_v_q <= 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						cnt_q   <= '0;
						hld_v_q <= 1'b0;
						state_q <= S_DISPATCH;
					end else if (cfg_valid) begin
						case (cfg_index)
							CFG_SAMPLE_RATE: begin
								rate_q  <= cfg_data;
								state_q <= S_RECOMP;
							end
							CFG_DURATION_NUM: begin
								num_q   <= cfg_data[DUR_W-1:0];
								state_q <= S_RECOMP;
							end
							CFG_DURATION_DEN: begin
								den_q   <= cfg_data[DUR_W-1:0];
								state_q <= S_RECOMP;
							end
							CFG_STRICT_MODE:  strict_q  <= cfg_data[0];
							CFG_REVERSE_PLAY: reverse_q <= cfg_data[0];
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RECOMP: begin
					if (md_req.start) begin
						state_q <= S_RECOMP_W;
					end else begin
						base_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_RECOMP_W: begin
					if (md_rsp.done) begin
						if (md_rsp.q == '0) begin
							base_q <= '0;
						end else begin
							base_q <= (|md_rsp.q[MD_P_W-1:FRAMES_W]) ? BASE_MAX
								: md_rsp.q[FRAMES_W-1:0];
							crem_q <= md_rsp.r[DUR_W-1:0];
							acc_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_DISPATCH: begin
					case (item_q.opcode)
						OP_ARRIVAL: begin
							if (base_q == '0) begin
								one_kind_q   <= KIND_NOT_CFG;
								one_frames_q <= item_q.frame_count;
								one_ret_q    <= S_FIN;
								state_q      <= S_PUT_ONE;
							end else if (item_q.discont || !ovalid_q) begin
								if (strict_q) begin
									if (pending_q != '0) begin
										one_kind_q   <= KIND_DISCARDED;
										one_frames_q <= pend_ext[FRAMES_W-1:0];
										one_ret_q    <= S_DISC_DONE;
										pending_q    <= '0;
										state_q      <= S_PUT_ONE;
									end else begin
										state_q <= S_DISC_DONE;
									end
								end else begin
									force_q <= 1'b1;
									limit_q <= MAX_RESULTS - CNT_W'(2);
									ret_q   <= S_DISC_DONE;
									state_q <= S_RC_TEST;
								end
							end else begin
								state_q <= S_CAP;
							end
						end
						OP_DRAIN: begin
							if (strict_q) begin
								if (pending_q != '0) begin
									one_kind_q   <= KIND_DISCARDED;
									one_frames_q <= pend_ext[FRAMES_W-1:0];
									one_ret_q    <= S_FIN;
									pending_q    <= '0;
									state_q      <= S_PUT_ONE;
								end else begin
									state_q <= S_FIN;
								end
							end else if (base_q != '0) begin
								force_q <= 1'b1;
								limit_q <= MAX_RESULTS - CNT_W'(1);
								ret_q   <= S_FIN;
								state_q <= S_RC_TEST;
							end else begin
								state_q <= S_FIN;
							end
						end
						OP_FLUSH: begin
							pending_q <= '0;
							roff_q    <= '0;
							acc_q     <= '0;
							ovalid_q  <= 1'b0;
							state_q   <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_DISC_DONE: begin
					roff_q   <= '0;
					acc_q    <= '0;
					rbase_q  <= item_q.arrival_time;
					ovalid_q <= 1'b1;
					state_q  <= S_CAP;
				end
				S_CAP: begin
					if (sum_ext > CAP) begin
						one_kind_q   <= KIND_OVERFLOW;
						one_frames_q <= item_q.frame_count;
						one_ret_q    <= S_FIN;
						state_q      <= S_PUT_ONE;
					end else begin
						pending_q <= PW'(sum_ext);
						force_q   <= 1'b0;
						limit_q   <= MAX_RESULTS;
						ret_q     <= S_FIN;
						state_q   <= S_RC_TEST;
					end
				end
				S_RC_TEST: begin
					start_q <= (roff_q == '0);
					noff_q  <= noff_raw[OFFSET_W] ? OFFSET_MAX : noff_raw[OFFSET_W-1:0];
					if (cnt_q >= limit_q) begin
						state_q <= S_RC_END;
					end else if (pend_ext >= size_ext) begin
						n_q     <= size;
						state_q <= S_CV1;
					end else if (force_q && pending_q != '0) begin
						n_q     <= SIZE_W'(pending_q);
						state_q <= S_CV1;
					end else begin
						state_q <= S_RC_END;
					end
				end
				S_CV1: state_q <= S_CV1_W;
				S_CV1_W: begin
					if (md_rsp.done) begin
						diff_q  <= conv;
						state_q <= S_CV2;
					end
				end
				S_CV2: state_q <= S_CV2_W;
				S_CV2_W: begin
					if (md_rsp.done) begin
						if (reverse_q) begin
							t_q   <= (rbase_q > diff_q) ? rbase_q - diff_q : '0;
							len_q <= conv;
						end else begin
							t_q   <= fsum[TIME_W] ? MAX63 : fsum[TIME_W-1:0];
							len_q <= conv - diff_q;
						end
						state_q <= S_PUT_CHUNK;
					end
				end
				S_PUT_CHUNK: begin
					if (!put_stall) begin
						roff_q    <= noff_q;
						acc_q     <= acc_next;
						pending_q <= PW'(pend_ext - SW'(n_q));
						state_q   <= S_RC_TEST;
					end
				end
				S_RC_END: begin
					if (force_q && pending_q != '0) begin
						one_kind_q   <= KIND_DISCARDED;
						one_frames_q <= pend_ext[FRAMES_W-1:0];
						one_ret_q    <= ret_q;
						pending_q    <= '0;
						state_q      <= S_PUT_ONE;
					end else begin
						state_q <= ret_q;
					end
				end
				S_PUT_ONE: begin
					if (!put_stall) state_q <= one_ret_q;
				end
				S_FIN: begin
					if (!hld_v_q) begin
						state_q <= S_IDLE;
					end else if (fin_move) begin
						out_q   <= fin_data;
						out_v_q <= 1'b1;
						hld_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/acp_checker.sv */
module acp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  acp_pkg::out_item_t             out_data,
	input  logic                           cfg_ready
);
	import acp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_cfg_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> in_ready && !in_valid)
		else $error("config open while busy or with an input waiting");

	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_CHUNK |->
			out_data.chunk_time == '0 && out_data.chunk_length == '0 && !out_data.starts_run)
		else $error("event beat carries timing fields");

endmodule

bind audio_chunk_planner_unit acp_checker u_acp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
	.cfg_ready(cfg_ready)
);
